### src/epfm_pkg.sv
package epfm_pkg;

    typedef struct packed {
        logic        has_stamp;
        logic [31:0] edge_stamp;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  stamps_kept;
        logic [6:0]  period_count;
        logic [6:0]  good_count;
        logic [31:0] mean_period;
        logic [31:0] period_spread;
        logic [31:0] timer_rate_echo;
        logic [41:0] freq_millihertz;
    } out_item_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FEW_EDGES = 2'd1;
    localparam logic [1:0] ST_FEW_ACC   = 2'd2;

    localparam logic [0:0] REG_EDGE_LIMIT = 1'b0;
    localparam logic [0:0] REG_TIMER_HZ   = 1'b1;

    localparam int MIN_EDGES = 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_MED,
        S_FILT_RD,
        S_FILT_ACC,
        S_DIV_AVG,
        S_MUL,
        S_DIV_FREQ,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

endpackage

### src/epfm_div.sv
module epfm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  epfm_pkg::div_req_t req,
    output logic               done,
    output logic [63:0]        quotient
);
    import epfm_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
            den_reg <= req.divisor;
    end

    assign done     = busy_reg && (cnt_reg == 7'd1);
    assign quotient = quo_next;
endmodule

### src/edge_period_frequency_meter.sv
// Edge-period frequency meter. Timestamps are taken one per cycle while no
// result is being formed; periods go to an internal RAM. The request with
// last_item set starts a result pass that holds busy high: with at least
// four stamps, an insertion sort over a second RAM (at most n*(n-1)/2
// shift steps for n periods) and a filter sweep; with at least two
// accepted periods, also two shift-subtract divisions. The result then
// appears on result for exactly one cycle with result_valid; it cannot be
// held off, so the receiver must take it then. Configuration writes are
// always ready and should only be made while busy is low.
module edge_period_frequency_meter #(
    parameter int MAX_EDGES = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  epfm_pkg::in_item_t    request,
    output logic                  result_valid,
    output epfm_pkg::out_item_t   result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import epfm_pkg::*;

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = CW + 32;

    logic [7:0]  limit_reg;
    logic [31:0] hz_reg;
    logic [31:0] prev_reg;
    logic [CW-1:0] count_reg;
    fsm_t        state_reg, state_next;

    logic [31:0] pmem [MAX_EDGES];
    logic [31:0] smem [MAX_EDGES];
    logic [31:0] prd_reg, srd_reg;
    logic        pwe, swe;
    logic [AW-1:0] pwa, pra, swa, sra;
    logic [31:0] pwd, swd;

    logic [CW-1:0] n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] lo_reg, lo_next;
    logic [32:0] hi_reg, hi_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [31:0] min_reg, min_next, max_reg, max_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] avg_reg, avg_next;
    logic [CW-1:0] edges_reg, edges_next;
    out_item_t   res_next, res_reg;
    logic        rv_next, rv_reg;

    div_req_t    dreq;
    logic        ddone;
    logic [63:0] dq;

    logic [CW-1:0] lim_c;
    logic        accept, take;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        if (limit_reg < 8'(MIN_EDGES))
            lim_c = CW'(MIN_EDGES);
        else if (32'(limit_reg) > 32'(MAX_EDGES))
            lim_c = CW'(MAX_EDGES);
        else
            lim_c = CW'(limit_reg);
    end

    assign take = accept && request.has_stamp && (count_reg < lim_c);

    epfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (dq)
    );

    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[pwa] <= pwd;
        prd_reg <= pmem[pra];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
            smem[swa] <= swd;
        srd_reg <= smem[sra];
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        key_next = key_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        sum_next = sum_reg;
        acc_next = acc_reg;
        min_next = min_reg;
        max_next = max_reg;
        prod_next = prod_reg;
        avg_next = avg_reg;
        edges_next = edges_reg;
        res_next = res_reg;
        rv_next = 1'b0;
        pwe = 1'b0;
        pwa = AW'(count_reg - CW'(1));
        pwd = request.edge_stamp - prev_reg;
        pra = AW'(i_reg);
        swe = 1'b0;
        swa = AW'(j_reg);
        swd = key_reg;
        sra = AW'(j_reg - CW'(1));
        dreq = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && count_reg != '0)
                begin
                    pwe = 1'b1;
                    swe = 1'b1;
                    swa = AW'(count_reg - CW'(1));
                    swd = pwd;
                end
                if (accept && request.last_item)
                begin
                    edges_next = take ? count_reg + CW'(1) : count_reg;
                    res_next = '0;
                    res_next.stamps_kept = 8'(edges_next);
                    if (edges_next < CW'(MIN_EDGES))
                    begin
                        res_next.status = ST_FEW_EDGES;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next = CW'(1);
                        n_next = edges_next - CW'(1);
                        res_next.period_count = 7'(edges_next - CW'(1));
                        state_next = S_SORT_RD;
                    end
                end
            end
            S_SORT_RD:
            begin
                if (i_reg >= n_reg)
                begin
                    sra = AW'(n_reg >> 1);
                    state_next = S_MED;
                end
                else
                begin
                    sra = AW'(i_reg);
                    j_next = i_reg;
                    state_next = S_SORT_KEY;
                end
            end
            S_SORT_KEY:
            begin
                key_next = srd_reg;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                swe = 1'b1;
                if (srd_reg > key_reg)
                begin
                    swd = srd_reg;
                    j_next = j_reg - CW'(1);
                    sra = AW'(j_reg - CW'(2));
                    if (j_next == '0)
                        state_next = S_SORT_PUT;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_SORT_RD;
                end
            end
            S_SORT_PUT:
            begin
                swe = 1'b1;
                i_next = i_reg + CW'(1);
                state_next = S_SORT_RD;
            end
            S_MED:
            begin
                lo_next = srd_reg - (srd_reg >> 2);
                hi_next = {1'b0, srd_reg} + {3'b0, srd_reg[31:2]};
                sum_next = '0;
                acc_next = '0;
                min_next = '1;
                max_next = '0;
                i_next = '0;
                pra = '0;
                state_next = S_FILT_RD;
            end
            S_FILT_RD:
            begin
                state_next = S_FILT_ACC;
            end
            S_FILT_ACC:
            begin
                if (prd_reg >= lo_reg && {1'b0, prd_reg} <= hi_reg)
                begin
                    sum_next = sum_reg + SW'(prd_reg);
                    acc_next = acc_reg + CW'(1);
                    if (prd_reg < min_reg)
                        min_next = prd_reg;
                    if (prd_reg > max_reg)
                        max_next = prd_reg;
                end
                i_next = i_reg + CW'(1);
                pra = AW'(i_next);
                if (i_next >= n_reg)
                begin
                    res_next.good_count = 7'(acc_next);
                    if (acc_next < CW'(2))
                    begin
                        res_next.status = ST_FEW_ACC;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.dividend = 64'(sum_next);
                        dreq.divisor = 64'(acc_next);
                        state_next = S_DIV_AVG;
                    end
                end
                else
                    state_next = S_FILT_RD;
            end
            S_DIV_AVG:
            begin
                prod_next = 64'(acc_reg) * 64'd1000;
                if (ddone)
                begin
                    avg_next = dq[31:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dreq.start = 1'b1;
                dreq.dividend = prod_reg[31:0] * 64'(hz_reg);
                dreq.divisor = 64'(sum_reg);
                state_next = S_DIV_FREQ;
            end
            S_DIV_FREQ:
            begin
                if (ddone)
                begin
                    res_next.status = ST_OK;
                    res_next.mean_period = avg_reg;
                    res_next.period_spread = max_reg - min_reg;
                    res_next.timer_rate_echo = hz_reg;
                    res_next.freq_millihertz = (sum_reg == '0) ? '0 : dq[41:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= 8'd64;
            hz_reg     <= 32'd170000000;
            prev_reg   <= '0;
            count_reg  <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rv_reg     <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_EDGE_LIMIT: limit_reg <= cfg_data[7:0];
                    REG_TIMER_HZ:   hz_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && request.last_item)
            begin
                prev_reg  <= '0;
                count_reg <= '0;
            end
            else if (take)
            begin
                prev_reg  <= request.edge_stamp;
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        i_reg <= i_next;
        j_reg <= j_next;
        key_reg <= key_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        sum_reg <= sum_next;
        acc_reg <= acc_next;
        min_reg <= min_next;
        max_reg <= max_next;
        prod_reg <= prod_next;
        avg_reg <= avg_next;
        edges_reg <= edges_next;
        res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> result_valid)
        else $error("missed result");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg == '0))
        else $error("count not cleared");
endmodule

### tb/epfm_checker.sv
module epfm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  epfm_pkg::in_item_t  request,
    input  logic                result_valid,
    input  epfm_pkg::out_item_t result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fails,
    output int                  pending
);
    import epfm_pkg::*;

    localparam int DEPTH = 128;

    logic [7:0]  lim_reg;
    logic [31:0] hz_reg;
    logic [31:0] last_stamp;
    logic [7:0]  kept;
    logic [31:0] periods [DEPTH];
    out_item_t   expected_q [$];

    assign pending = expected_q.size();

    function automatic int clamped_limit();
        int l;
        l = lim_reg;
        if (l < MIN_EDGES) l = MIN_EDGES;
        if (l > DEPTH) l = DEPTH;
        return l;
    endfunction

    function automatic out_item_t close_window(int edges);
        out_item_t   r;
        logic [31:0] srt [DEPTH];
        logic [31:0] key, med, lo, pmin, pmax, p;
        logic [32:0] hi;
        logic [63:0] sum, prod;
        int          n, j, acc;
        r = '0;
        r.stamps_kept = edges[7:0];
        if (edges < MIN_EDGES) begin
            r.status = ST_FEW_EDGES;
            return r;
        end
        n = edges - 1;
        r.period_count = n[6:0];
        for (int i = 0; i < n; i++) srt[i] = periods[i];
        for (int i = 1; i < n; i++) begin
            key = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > key) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = key;
        end
        med = srt[n/2];
        lo = med - med / 4;
        hi = {1'b0, med} + {3'b0, med[31:2]};
        sum = 0;
        acc = 0;
        pmin = '1;
        pmax = 0;
        for (int i = 0; i < n; i++) begin
            p = periods[i];
            if (p >= lo && {1'b0, p} <= hi) begin
                sum += p;
                acc++;
                if (p < pmin) pmin = p;
                if (p > pmax) pmax = p;
            end
        end
        r.good_count = acc[6:0];
        if (acc < 2) begin
            r.status = ST_FEW_ACC;
            return r;
        end
        r.status = ST_OK;
        r.mean_period = 32'(sum / acc);
        r.period_spread = pmax - pmin;
        r.timer_rate_echo = hz_reg;
        prod = 64'(acc) * 64'd1000 * 64'(hz_reg);
        r.freq_millihertz = (sum != 0) ? 42'(prod / sum) : '0;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t e;
        int edges;
        if (!rst_n) begin
            lim_reg <= 8'd64;
            hz_reg <= 32'd170000000;
            last_stamp <= '0;
            kept <= '0;
            expected_q.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EDGE_LIMIT) lim_reg <= cfg_data[7:0];
                else hz_reg <= cfg_data;
            end
            if (start && !busy) begin
                edges = kept;
                if (request.has_stamp && kept < clamped_limit()) begin
                    if (kept > 0) periods[kept-1] = request.edge_stamp - last_stamp;
                    last_stamp <= request.edge_stamp;
                    edges = kept + 1;
                    kept <= kept + 1;
                end
                if (request.last_item) begin
                    expected_q.push_back(close_window(edges));
                    last_stamp <= '0;
                    kept <= '0;
                end
            end
            if (result_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("status", e.status, result.status);
                    check_field("stamps_kept", e.stamps_kept, result.stamps_kept);
                    check_field("period_count", e.period_count, result.period_count);
                    check_field("good_count", e.good_count, result.good_count);
                    check_field("mean_period", e.mean_period, result.mean_period);
                    check_field("period_spread", e.period_spread, result.period_spread);
                    check_field("timer_rate_echo", e.timer_rate_echo, result.timer_rate_echo);
                    check_field("freq_millihertz", e.freq_millihertz,
                                result.freq_millihertz);
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import epfm_pkg::*;

    localparam int ITEM_GOAL = 1500;
    localparam int STALL_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    request = '0;
    logic        result_valid;
    out_item_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_EDGE_LIMIT;
    logic [31:0] cfg_data = '0;
    int          fails;
    int          pending;
    int          sent = 0;
    int          idle_pct = 0;
    int          quiet = 0;

    always #6 clk = ~clk;

    edge_period_frequency_meter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    epfm_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(logic hs, logic [31:0] stamp, logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= '{has_stamp: hs, edge_stamp: stamp, last_item: last};
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one window of stamps around a nominal period, optional outliers
    task automatic window(int n, logic [31:0] nominal, bit outliers);
        logic [31:0] t, jit, p;
        bit joint;
        t = $urandom();
        jit = nominal / 8;
        joint = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) send(1'b0, $urandom(), 1'b0);
            send(1'b1, t, joint && i == n - 1);
            p = nominal + $urandom_range(0, 2 * jit) - jit;
            if (outliers && $urandom_range(0, 7) == 0) p = $urandom();
            t += p;
        end
        if (!joint || n == 0) send(1'b0, $urandom(), 1'b1);
    endtask

    initial begin
        logic [31:0] nom;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b0, 32'hFFFF_FFFF, 1'b1);
        send(1'b0, 32'h0, 1'b0);
        send(1'b1, 32'hFFFF_FFF0, 1'b0);
        send(1'b1, 32'h0000_0010, 1'b0);
        send(1'b1, 32'h0000_0030, 1'b0);
        send(1'b1, 32'h0000_0050, 1'b1);
        for (int i = 0; i < 5; i++) send(1'b1, 32'h1234_5678, i == 4);
        send(1'b1, 32'd0, 1'b0);
        send(1'b1, 32'd1, 1'b0);
        send(1'b1, 32'd101, 1'b0);
        send(1'b1, 32'd10101, 1'b1);
        write_reg(REG_EDGE_LIMIT, 32'd0);
        write_reg(REG_TIMER_HZ, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send(1'b1, 32'(i * 1000), 1'b0);
        send(1'b1, 32'd9999, 1'b1);
        send(1'b1, 32'd0, 1'b0);
        send(1'b1, 32'd50, 1'b0);
        write_reg(REG_EDGE_LIMIT, 32'd255);
        write_reg(REG_TIMER_HZ, 32'd1);
        for (int i = 2; i < 8; i++) send(1'b1, 32'(i * 50), i == 7);

        while (sent < ITEM_GOAL) begin
            case ((sent * 4) / ITEM_GOAL)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 0;
                default: idle_pct = 28;
            endcase
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0: write_reg(REG_EDGE_LIMIT, 32'd4);
                    1: write_reg(REG_EDGE_LIMIT, 32'd128);
                    2: write_reg(REG_EDGE_LIMIT, 32'd255);
                    default: write_reg(REG_EDGE_LIMIT, $urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(REG_TIMER_HZ, 32'd1);
                    1: write_reg(REG_TIMER_HZ, 32'hFFFF_FFFF);
                    2: write_reg(REG_TIMER_HZ, 32'd170000000);
                    default: write_reg(REG_TIMER_HZ, $urandom());
                endcase
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
                                             : $urandom_range(0, 20);
            case ($urandom_range(0, 3))
                0: nom = $urandom_range(0, 50);
                1: nom = $urandom_range(1000, 100000);
                2: nom = $urandom_range(0, 32'h7FFF_FFFF);
                default: nom = $urandom();
            endcase
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < n; i++)
                    send($urandom_range(0, 1), $urandom(), $urandom_range(0, 7) == 0);
                send(1'b0, $urandom(), 1'b1);
            end else begin
                window(n, nom, $urandom_range(0, 2) == 0);
            end
        end

        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
